### hdl/assert_macros.svh
// Assertion macros shared by the sanitiser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define USV_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent must hold whenever the antecedent does, outside reset.
`define USV_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/usv_pkg.sv
package usv_pkg;

   // Byte classification masks and tags.
   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] CONT_MASK   = 8'hC0;
   localparam logic [7:0] CONT_TAG    = 8'h80;
   localparam logic [7:0] LEAD2_MASK  = 8'hE0;
   localparam logic [7:0] LEAD2_TAG   = 8'hC0;
   localparam logic [7:0] LEAD3_MASK  = 8'hF0;
   localparam logic [7:0] LEAD3_TAG   = 8'hE0;
   localparam logic [7:0] LEAD4_MASK  = 8'hF8;
   localparam logic [7:0] LEAD4_TAG   = 8'hF0;

   // Continuation bytes still missing after each lead form.
   localparam logic [1:0] NEED_LEAD2 = 2'd1;
   localparam logic [1:0] NEED_LEAD3 = 2'd2;
   localparam logic [1:0] NEED_LEAD4 = 2'd3;

   // Number of pending bytes that can be held.
   localparam int HELD_DEPTH = 3;

   // One burst of results caused by a single input transfer.
   typedef struct packed {
      logic [3:0][7:0] bytes;     // bytes in emission order, entry 0 first
      logic [1:0]      last_idx;  // index of the final byte of the burst
      logic            marker;    // end-of-message marker without data
      logic            msg_end;   // final burst of the message
   } burst_type;

   // Queue status seen by the front and back ends.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

### hdl/usv_front.sv
module usv_front
   import usv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tlast,
   input  q_status_type q_status,
   output logic         push,
   output burst_type    push_data
);

   logic [7:0] held_ff [HELD_DEPTH];
   logic [7:0] held_in [HELD_DEPTH];
   logic [1:0] held_count_ff, held_count_in;
   logic [1:0] needed_count_ff, needed_count_in;
   logic       is_cont;
   logic       fresh;
   logic [2:0] n_out;
   logic       accept;
   burst_type  burst;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign is_cont    = (req_tdata & CONT_MASK) == CONT_TAG;

   // Classify the byte against the pending sequence and build its burst.
   always_comb begin
      held_in         = held_ff;
      held_count_in   = held_count_ff;
      needed_count_in = needed_count_ff;
      burst           = '0;
      n_out           = 3'd0;
      fresh           = 1'b1;

      if (held_count_ff != 2'd0) begin
         if (is_cont) begin
            fresh = 1'b0;
            if (needed_count_ff <= 2'd1) begin
               // Sequence complete: held bytes followed by this byte.
               for (int i = 0; i < HELD_DEPTH; i++) begin
                  if (2'(i) < held_count_ff) begin
                     burst.bytes[i] = held_ff[i];
                  end
               end
               burst.bytes[held_count_ff] = req_tdata;
               n_out           = {1'b0, held_count_ff} + 3'd1;
               held_count_in   = 2'd0;
               needed_count_in = 2'd0;
            end else if (held_count_ff < 2'(HELD_DEPTH)) begin
               held_in[held_count_ff] = req_tdata;
               held_count_in          = held_count_ff + 2'd1;
               needed_count_in        = needed_count_ff - 2'd1;
            end else begin
               held_count_in   = 2'd0;
               needed_count_in = 2'd0;
            end
         end else begin
            // Broken sequence: drop what is held and start afresh.
            held_count_in   = 2'd0;
            needed_count_in = 2'd0;
         end
      end

      if (fresh) begin
         if (req_tdata < ASCII_LIMIT) begin
            burst.bytes[0] = req_tdata;
            n_out          = 3'd1;
         end else if ((req_tdata & LEAD2_MASK) == LEAD2_TAG) begin
            held_in[0]      = req_tdata;
            held_count_in   = 2'd1;
            needed_count_in = NEED_LEAD2;
         end else if ((req_tdata & LEAD3_MASK) == LEAD3_TAG) begin
            held_in[0]      = req_tdata;
            held_count_in   = 2'd1;
            needed_count_in = NEED_LEAD3;
         end else if ((req_tdata & LEAD4_MASK) == LEAD4_TAG) begin
            held_in[0]      = req_tdata;
            held_count_in   = 2'd1;
            needed_count_in = NEED_LEAD4;
         end
      end

      // The end of the message discards any incomplete sequence.
      if (req_tlast) begin
         held_count_in   = 2'd0;
         needed_count_in = 2'd0;
         burst.msg_end   = 1'b1;
         if (n_out == 3'd0) begin
            burst.marker = 1'b1;
            n_out        = 3'd1;
         end
      end

      burst.last_idx = 2'(n_out - 3'd1);
   end

   assign push      = accept && (n_out != 3'd0);
   assign push_data = burst;

   // Pending sequence state.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff   <= 2'd0;
         needed_count_ff <= 2'd0;
      end else if (accept) begin
         held_count_ff   <= held_count_in;
         needed_count_ff <= needed_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   `include "assert_macros.svh"

   `USV_ASSERT_IMPL(a_held_fits, clock, reset, held_count_ff != 2'd0, ({1'b0, held_count_ff} + {1'b0, needed_count_ff}) <= 3'd4, "held and needed counts exceed a sequence")
   `USV_ASSERT_IMPL(a_need_with_held, clock, reset, held_count_ff != 2'd0, needed_count_ff != 2'd0, "bytes held with nothing needed")
   `USV_ASSERT_IMPL(a_idle_clear, clock, reset, held_count_ff == 2'd0, needed_count_ff == 2'd0, "bytes needed with nothing held")

endmodule

### hdl/usv_queue.sv
module usv_queue
   import usv_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  burst_type    push_data,
   input  logic         pop,
   output burst_type    pop_data,
   output q_status_type q_status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   burst_type        entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_status.full  = count_ff == CNT_W'(DEPTH);
   assign q_status.empty = count_ff == '0;
   assign pop_data       = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `include "assert_macros.svh"

   `USV_ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count beyond depth")
   `USV_ASSERT_IMPL(a_no_overflow, clock, reset, push, !q_status.full, "push into a full queue")
   `USV_ASSERT_IMPL(a_no_underflow, clock, reset, pop, !q_status.empty, "pop from an empty queue")

endmodule

### hdl/usv_back.sv
module usv_back
   import usv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  burst_type    pop_data,
   output logic         pop,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);

   burst_type  cur_ff, cur_in;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_take;
   logic       at_end;
   logic       need_load;

   assign out_take  = valid_ff && rsp_tready;
   assign at_end    = idx_ff == cur_ff.last_idx;
   assign need_load = !valid_ff || (out_take && at_end);
   assign pop       = need_load && !q_status.empty;

   // Step through the current burst and fetch the next one at its end.
   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (need_load) begin
         valid_in = !q_status.empty;
         cur_in   = pop_data;
         idx_in   = 2'd0;
      end else if (out_take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = cur_ff.marker ? 8'h00 : cur_ff.bytes[idx_ff];
   assign rsp_tuser[0] = !cur_ff.marker;
   assign rsp_tuser[1] = at_end;
   assign rsp_tlast    = at_end && cur_ff.msg_end;

   `include "assert_macros.svh"

   `USV_ASSERT_IMPL(a_marker_closes, clock, reset, valid_ff && cur_ff.marker, at_end && cur_ff.msg_end, "marker result does not close the message")
   `USV_ASSERT_IMPL(a_idx_range, clock, reset, valid_ff, idx_ff <= cur_ff.last_idx, "burst index past its last byte")

endmodule

### hdl/utf8_sequence_sanitizer_unit.sv
// UTF-8 sequence sanitiser.
// The req channel takes one raw byte per transfer in req_tdata, with req_tlast
// marking the final byte of a message. The rsp channel returns only bytes of
// well-formed sequences: ASCII bytes pass at once, a multi-byte sequence is
// released whole when its last continuation byte arrives. Each rsp transfer
// carries one byte; rsp_tuser[1] marks the last result caused by one input
// byte and rsp_tlast the final result of the message. A message whose final
// byte completes nothing is closed by a marker transfer with rsp_tuser[0] low.
// A byte is accepted every cycle while the burst queue has room; results leave
// at one per cycle while rsp_tready is high, so a completed four-byte sequence
// takes four rsp transfers and the queue of QUEUE_DEPTH bursts absorbs the
// difference. The first result of a byte passes a queue entry, then cur_ff.
// Reset clears the pending sequence, the queue and the output stage; no
// result is pending afterwards. When the receiver stalls, the output holds
// its transfer, the queue fills, and req_tready falls once it is full.
module utf8_sequence_sanitizer_unit
   import usv_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] byte_valid, [1] run_last
   output logic       rsp_tlast
);

   q_status_type q_status;
   logic         push;
   logic         pop;
   burst_type    push_data;
   burst_type    pop_data;

   usv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .push_data  (push_data)
   );

   usv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   usv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### tb/tb_utf8_sequence_sanitizer_unit.sv
`timescale 1ns / 1ps

module tb_utf8_sequence_sanitizer_unit;
   import usv_pkg::*;

   localparam int RANDOM_ITEMS   = 286;
   localparam int STALL_LIMIT    = 2000;
   localparam int HOLD_OFF_AFTER = 60;
   localparam int HOLD_OFF_LEN   = 200;
   localparam int REPORT_LIMIT   = 10;

   // One byte leaving the sanitiser, with its side flags.
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       run_last;
      logic       msg_end;
   } emitted_byte_type;

   // Tracks the pending UTF-8 sequence and the bytes that must come out, in order.
   class utf8_scoreboard;
      logic [7:0]       held [3];
      int               held_cnt = 0;
      int               need_cnt = 0;
      emitted_byte_type pending [$];
      int               errors = 0;

      // Works out the results caused by one accepted input transfer.
      function void note_input(logic [7:0] b, logic msg_last);
         emitted_byte_type run [4];
         int               n;
         bit               fresh;
         bit               cont;
         n = 0;
         fresh = 1'b1;
         cont = ((b & CONT_MASK) == CONT_TAG);

         // A continuation either extends or completes the held sequence;
         // anything else breaks it and is then handled as a new byte.
         if (held_cnt != 0) begin
            if (cont) begin
               fresh = 1'b0;
               if (need_cnt <= 1) begin
                  for (int i = 0; i < held_cnt; i++) begin
                     run[n] = '{held[i], 1'b1, 1'b0, 1'b0};
                     n++;
                  end
                  run[n] = '{b, 1'b1, 1'b0, 1'b0};
                  n++;
                  held_cnt = 0;
                  need_cnt = 0;
               end else begin
                  held[held_cnt] = b;
                  held_cnt++;
                  need_cnt--;
               end
            end else begin
               held_cnt = 0;
               need_cnt = 0;
            end
         end

         // Stray continuations and bytes of 0xF8 and above fall through unused.
         if (fresh) begin
            if (b < ASCII_LIMIT) begin
               run[n] = '{b, 1'b1, 1'b0, 1'b0};
               n++;
            end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
               held[0] = b;
               held_cnt = 1;
               need_cnt = int'(NEED_LEAD2);
            end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
               held[0] = b;
               held_cnt = 1;
               need_cnt = int'(NEED_LEAD3);
            end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
               held[0] = b;
               held_cnt = 1;
               need_cnt = int'(NEED_LEAD4);
            end
         end

         // The end of a message drops an unfinished sequence and always yields a result.
         if (msg_last) begin
            held_cnt = 0;
            need_cnt = 0;
            if (n == 0) begin
               run[0] = '{8'h00, 1'b0, 1'b0, 1'b0};
               n = 1;
            end
            run[n-1].msg_end = 1'b1;
         end

         if (n > 0) begin
            run[n-1].run_last = 1'b1;
         end
         for (int i = 0; i < n; i++) begin
            pending.insert(pending.size(), run[i]);
         end
      endfunction

      // Compares one result transfer with the oldest expected byte.
      function void check_result(logic [7:0] data, logic [1:0] user, logic lst);
         emitted_byte_type got;
         emitted_byte_type want;
         got = '{data, user[0], user[1], lst};
         if (pending.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("unexpected result: data=%h valid=%b run_last=%b msg_end=%b",
                        got.data, got.valid, got.run_last, got.msg_end);
            end
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display({"mismatch: expected data=%h valid=%b run_last=%b msg_end=%b,",
                         " got data=%h valid=%b run_last=%b msg_end=%b"},
                        want.data, want.valid, want.run_last, want.msg_end,
                        got.data, got.valid, got.run_last, got.msg_end);
            end
         end
      endfunction
   endclass

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] in_byte
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic [1:0] rsp_tuser;            // [0] byte_valid, [1] run_last
   logic       rsp_tlast;

   utf8_scoreboard book = new();
   bit             send_calm = 1'b0;
   bit             take_calm = 1'b0;
   bit             held_off  = 1'b0;
   int             taken     = 0;
   int             idle_cycles = 0;

   utf8_sequence_sanitizer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offers one byte after a random pause and waits for its transfer.
   task automatic send_byte(input logic [7:0] b, input logic msg_last);
      int gap;
      if ($urandom_range(0, 15) == 0) begin
         send_calm = !send_calm;
      end
      gap = send_calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= msg_last;
      do @(posedge clock); while (!req_tready);
      book.note_input(b, msg_last);
   endtask

   function automatic logic draw_end();
      return ($urandom_range(0, 11) == 0);
   endfunction

   function automatic logic [7:0] draw_lead(input int len);
      case (len)
         2: begin
            return LEAD2_TAG | 8'($urandom_range(0, 31));
         end
         3: begin
            return LEAD3_TAG | 8'($urandom_range(0, 15));
         end
         default: begin
            return LEAD4_TAG | 8'($urandom_range(0, 7));
         end
      endcase
   endfunction

   function automatic logic [7:0] draw_cont();
      return CONT_TAG | 8'($urandom_range(0, 63));
   endfunction

   // Stimulus: reset, a directed opening, then mostly well-formed random text.
   initial begin
      int sent;
      int pick;
      int len;
      int cut;
      sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ASCII extremes, then the smallest two-byte lead and the largest three- and four-byte leads.
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hC0, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hF7, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'h80, 1'b0);
      // Stray continuation and invalid leads are dropped.
      send_byte(8'h80, 1'b0);
      send_byte(8'hF8, 1'b0);
      send_byte(8'hFF, 1'b0);
      // A sequence broken by ASCII, then one broken by a new lead.
      send_byte(8'hC3, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h9F, 1'b0);
      // The message ends inside a sequence, so only the marker comes out.
      send_byte(8'h98, 1'b1);
      // End of message on a completing byte and on a plain ASCII byte.
      send_byte(8'hC2, 1'b0);
      send_byte(8'hA9, 1'b1);
      send_byte(8'h41, 1'b1);

      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            send_byte(8'($urandom_range(0, 127)), draw_end());
            sent++;
         end else if (pick < 8) begin
            len = $urandom_range(2, 4);
            send_byte(draw_lead(len), draw_end());
            for (int k = 1; k < len; k++) begin
               send_byte(draw_cont(), draw_end());
            end
            sent += len;
         end else if (pick == 8) begin
            // Truncated sequence: the next item breaks it unless that item is a continuation.
            len = $urandom_range(3, 4);
            cut = $urandom_range(1, len - 1);
            send_byte(draw_lead(len), draw_end());
            for (int k = 1; k < cut; k++) begin
               send_byte(draw_cont(), draw_end());
            end
            sent += cut;
         end else begin
            send_byte(8'($urandom_range(0, 255)), draw_end());
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      while (book.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (book.errors == 0) begin
         $display("tb_utf8_sequence_sanitizer_unit: done, clean");
      end else begin
         $display("tb_utf8_sequence_sanitizer_unit: done, errors");
      end
      $finish;
   end

   // Receiver: random stalls per result, and one long hold-off that backs the queue up.
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && taken >= HOLD_OFF_AFTER) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_LEN) @(posedge clock);
         end
         if ($urandom_range(0, 15) == 0) begin
            take_calm = !take_calm;
         end
         gap = take_calm ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   // Every result transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         book.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Watchdog on cycles in which neither channel completes a transfer.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_utf8_sequence_sanitizer_unit: done, errors");
         $finish;
      end
   end

endmodule
